// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the deque unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define CBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deque check failed");

// clocked check that also holds during reset
`define CBD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("deque check failed");

`endif

// ===== sv/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// types and codes shared by the deque controller and datapath
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int DepthDef = 16;

  localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
  localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [1:0] FUNC_POP_BACK   = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // carry out the captured operation
  } cmd_t;

endpackage

// ===== sv/circular_buffer_deque_unit.sv =====
// ----------------------------------------------------------------------------
// circular_buffer_deque_unit
// double-ended queue held in a ring of DEPTH slots (DEPTH-1 usable)
// ----------------------------------------------------------------------------
// usage:
//   a request (func_i, value_in_i) is taken at a rising edge where start_i
//   is high and busy_o is low. func_i selects push front, push back,
//   pop front or pop back; value_in_i is only used by pushes.
//   exactly one result per request appears on value_out_o / status_o for a
//   single cycle, flagged by done_o; the receiver must take it then, there
//   is no way to stall it.
// sequence: the accepting edge captures the request; in the execute state
//   the indices are updated and the slot memory, whose read data is
//   registered, is accessed; the result is shown in the respond state.
// overlap: a new request may be taken in the same cycle the previous result
//   is shown, and busy_o is high only during the memory access cycle.
// reset: both ring indices return to zero, so the deque is empty; the slot
//   memory is not cleared, since a pop only reads slots filled earlier.
// ----------------------------------------------------------------------------
module circular_buffer_deque_unit #(
  parameter int DEPTH = cbd_pkg::DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic signed [31:0]  value_in_i,
  output logic                done_o,
  output logic signed [31:0]  value_out_o,
  output logic [1:0]          status_o
);

  // command bundle from sequencer to datapath
  cbd_pkg::cmd_t cmd;

  // sequencer: idle / execute / respond
  cbd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // indices, full/empty detection, slot memory and result registers
  cbd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .value_in_i  (value_in_i),
    .value_out_o (value_out_o),
    .status_o    (status_o)
  );

endmodule

// ===== sv/cbd_datapath.sv =====
// ----------------------------------------------------------------------------
// cbd_datapath
// ring indices, slot memory and result registers of the deque
// ----------------------------------------------------------------------------
module cbd_datapath #(
  parameter int DEPTH = cbd_pkg::DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbd_pkg::cmd_t       cmd_i,
  input  logic [1:0]          func_i,
  input  logic signed [31:0]  value_in_i,
  output logic signed [31:0]  value_out_o,
  output logic [1:0]          status_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [31:0]   mem [DEPTH];

  logic [1:0]    func_q;
  logic [31:0]   value_q;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [1:0]    status_q, status_d;
  logic          pop_ok_q, pop_ok_d;
  logic [31:0]   rdata_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] front_nx, front_pv, back_nx, back_pv;
  logic          full, empty;

  assign front_nx = (front_q == LastIdx) ? '0 : front_q + AW'(1);
  assign front_pv = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign back_nx  = (back_q == LastIdx) ? '0 : back_q + AW'(1);
  assign back_pv  = (back_q == '0) ? LastIdx : back_q - AW'(1);
  assign full     = (back_nx == front_q);
  assign empty    = (back_q == front_q);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    if (cmd_i.exec) begin
      status_d = cbd_pkg::STATUS_OK;
      pop_ok_d = 1'b0;
      case (func_q)
        cbd_pkg::FUNC_PUSH_FRONT: begin
          if (full) begin
            status_d = cbd_pkg::STATUS_OVERFLOW;
          end else begin
            front_d = front_pv;
            wr_en   = 1'b1;
            wr_addr = front_pv;
          end
        end
        cbd_pkg::FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = cbd_pkg::STATUS_OVERFLOW;
          end else begin
            back_d  = back_nx;
            wr_en   = 1'b1;
            wr_addr = back_q;
          end
        end
        cbd_pkg::FUNC_POP_FRONT: begin
          if (empty) begin
            status_d = cbd_pkg::STATUS_UNDERFLOW;
          end else begin
            front_d  = front_nx;
            rd_en    = 1'b1;
            rd_addr  = front_q;
            pop_ok_d = 1'b1;
          end
        end
        default: begin
          if (empty) begin
            status_d = cbd_pkg::STATUS_UNDERFLOW;
          end else begin
            back_d   = back_pv;
            rd_en    = 1'b1;
            rd_addr  = back_pv;
            pop_ok_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      status_q <= cbd_pkg::STATUS_OK;
      pop_ok_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      back_q   <= back_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // captured request, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= value_in_i;
    end
  end

  // slot memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign value_out_o = pop_ok_q ? rdata_q : '0;
  assign status_o    = status_q;

endmodule

// ===== sv/cbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbd_ctrl
// request sequencing for the deque: capture, execute, respond
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            done_o,
  output cbd_pkg::cmd_t   cmd_o
);

  cbd_pkg::state_e state_q, state_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    busy_o    = 1'b0;
    done_o    = 1'b0;
    accept    = 1'b0;
    cmd_o     = '0;
    case (state_q)
      cbd_pkg::ST_IDLE: begin
        accept = start_i;
      end
      cbd_pkg::ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = cbd_pkg::ST_RESP;
      end
      cbd_pkg::ST_RESP: begin
        done_o  = 1'b1;
        accept  = start_i;
        state_d = cbd_pkg::ST_IDLE;
      end
      default: begin
        state_d = cbd_pkg::ST_IDLE;
      end
    endcase
    if (accept) begin
      cmd_o.load = 1'b1;
      state_d    = cbd_pkg::ST_EXEC;
    end
  end

  `CBD_ASSERT(a_accept_then_exec, clk_i, rst_ni, (start_i && !busy_o) |=> cmd_o.exec)
  `CBD_ASSERT(a_exec_then_done, clk_i, rst_ni, cmd_o.exec |=> (done_o && !busy_o))
  `CBD_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(cmd_o.exec))
  `CBD_ASSERT_ALWAYS(a_no_load_in_exec, clk_i, !(cmd_o.load && cmd_o.exec))

endmodule

// ===== bench/circular_buffer_deque_unit_tb.sv =====
// ----------------------------------------------------------------------------
// circular_buffer_deque_unit_tb
// self-checking bench for the ring-buffer deque unit
// ----------------------------------------------------------------------------
// a short table of hand-picked requests covers the empty and full corners,
// wrap of the front ring index and the extreme data values. Long random runs
// follow, with the push/pop mix changing from burst to burst so the deque
// keeps swinging between empty and full. Fixed table rows are checked against
// results typed in, all other results against a behavioural deque kept in the bench.
// ----------------------------------------------------------------------------
module circular_buffer_deque_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth       = cbd_pkg::DepthDef;
  localparam int RandomReqs  = 1000;
  localparam int QuietTail   = 150;     // last random requests go back to back
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;       // extra wait after the last result

  // dut signals
  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         func_i;
  logic signed [31:0] value_in_i;
  logic               done_o;
  logic signed [31:0] value_out_o;
  logic [1:0]         status_o;

  circular_buffer_deque_unit #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .value_in_i (value_in_i),
    .done_o     (done_o),
    .value_out_o(value_out_o),
    .status_o   (status_o)
  );

  // one expected result, tagged with the request number for reporting
  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
    int unsigned        seq;
  } deque_result_t;

  // row of the directed table; a fixed row carries its result typed in
  typedef struct {
    logic [1:0]  op;
    logic [31:0] data;
    bit          fixed;
    logic [31:0] want_value;
    logic [1:0]  want_status;
  } dir_row_t;

  deque_result_t pending_results[$];
  dir_row_t      dir_rows[$];

  // bench copy of the deque
  logic [31:0] ring_slots[Depth];
  int          head_idx;
  int          tail_idx;

  int unsigned mismatch_cnt;
  int unsigned req_cnt;
  int unsigned result_cnt;
  int unsigned push_cnt;
  int unsigned pop_cnt;
  int unsigned overflow_cnt;
  int unsigned underflow_cnt;
  int unsigned max_fill;
  int unsigned cycle_cnt;

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_cnt, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioural deque: applies one request and returns what the unit owes
  // ---------------------------------------------------------------------------
  function automatic deque_result_t deque_apply(logic [1:0] op, logic [31:0] data);
    deque_result_t res;
    bit            is_full;
    bit            is_empty;
    int unsigned   fill;
    is_full    = ((tail_idx + 1) % Depth) == head_idx;
    is_empty   = tail_idx == head_idx;
    res.value  = '0;
    res.status = cbd_pkg::STATUS_OK;
    res.seq    = req_cnt;
    case (op)
      cbd_pkg::FUNC_PUSH_FRONT: begin
        push_cnt++;
        if (is_full) begin
          res.status = cbd_pkg::STATUS_OVERFLOW;
        end else begin
          head_idx             = (head_idx + Depth - 1) % Depth;
          ring_slots[head_idx] = data;
        end
      end
      cbd_pkg::FUNC_PUSH_BACK: begin
        push_cnt++;
        if (is_full) begin
          res.status = cbd_pkg::STATUS_OVERFLOW;
        end else begin
          ring_slots[tail_idx] = data;
          tail_idx             = (tail_idx + 1) % Depth;
        end
      end
      cbd_pkg::FUNC_POP_FRONT: begin
        pop_cnt++;
        if (is_empty) begin
          res.status = cbd_pkg::STATUS_UNDERFLOW;
        end else begin
          res.value = ring_slots[head_idx];
          head_idx  = (head_idx + 1) % Depth;
        end
      end
      default: begin
        pop_cnt++;
        if (is_empty) begin
          res.status = cbd_pkg::STATUS_UNDERFLOW;
        end else begin
          tail_idx  = (tail_idx + Depth - 1) % Depth;
          res.value = ring_slots[tail_idx];
        end
      end
    endcase
    if (res.status == cbd_pkg::STATUS_OVERFLOW) overflow_cnt++;
    if (res.status == cbd_pkg::STATUS_UNDERFLOW) underflow_cnt++;
    fill = (tail_idx - head_idx + Depth) % Depth;
    if (fill > max_fill) max_fill = fill;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned seq,
                                 logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch on request %0d: %s expected %h got %h",
             $realtime, seq, what, want, got);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: the unit cannot be stalled, so every done_o strobe is
  // matched against the oldest outstanding expectation on the spot
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        report_mismatch("done_o known", 0, 32'd1, {31'd0, done_o});
      end else if (done_o) begin
        result_cnt++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, 32'd0,
                          value_out_o);
        end else begin
          want = pending_results.pop_front();
          if (value_out_o !== want.value)
            report_mismatch("value_out", want.seq, want.value, value_out_o);
          if (status_o !== want.status)
            report_mismatch("status", want.seq, {30'd0, want.status},
                            {30'd0, status_o});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driving, always from a falling edge
  // ---------------------------------------------------------------------------

  // holds start_i until the unit takes the request; leaves start_i high so a
  // following request can go out back to back, returns at a falling edge
  task automatic issue_request(logic [1:0] op, logic [31:0] data,
                               bit fixed = 1'b0, logic [31:0] want_value = '0,
                               logic [1:0] want_status = cbd_pkg::STATUS_OK);
    deque_result_t res;
    start_i    <= 1'b1;
    func_i     <= op;
    value_in_i <= data;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    res = deque_apply(op, data);
    if (fixed) begin
      res.value  = want_value;
      res.status = want_status;
    end
    pending_results.push_back(res);
    req_cnt++;
    @(negedge clk_i);
  endtask

  // drops start_i for a burst of cycles with junk on the request fields
  task automatic idle_gap(int unsigned cycles);
    start_i    <= 1'b0;
    func_i     <= 2'($urandom);
    value_in_i <= $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  // mostly plain random words, with the corner values thrown in often
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(logic [1:0] op, logic [31:0] data, bit fixed,
                                  logic [31:0] want_value, logic [1:0] want_status);
    dir_row_t row;
    row.op          = op;
    row.data        = data;
    row.fixed       = fixed;
    row.want_value  = want_value;
    row.want_status = want_status;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned burst_left;
    int unsigned push_bias;
    bit          idle_on;
    logic [1:0]  op;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    func_i        = cbd_pkg::FUNC_PUSH_FRONT;
    value_in_i    = '0;
    head_idx      = 0;
    tail_idx      = 0;
    mismatch_cnt  = 0;
    req_cnt       = 0;
    result_cnt    = 0;
    push_cnt      = 0;
    pop_cnt       = 0;
    overflow_cnt  = 0;
    underflow_cnt = 0;
    max_fill      = 0;
    cycle_cnt     = 0;
    foreach (ring_slots[i]) ring_slots[i] = '0;

    // directed table
    // pops straight after reset find the deque empty
    add_row(cbd_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'd0,
            cbd_pkg::STATUS_UNDERFLOW);
    add_row(cbd_pkg::FUNC_POP_BACK,   32'hffff_ffff, 1'b1, 32'd0,
            cbd_pkg::STATUS_UNDERFLOW);
    // largest and smallest values through both ends; front push wraps to top
    add_row(cbd_pkg::FUNC_PUSH_BACK,  32'h7fff_ffff, 1'b1, 32'd0,
            cbd_pkg::STATUS_OK);
    add_row(cbd_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'd0,
            cbd_pkg::STATUS_OK);
    add_row(cbd_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'h8000_0000,
            cbd_pkg::STATUS_OK);
    add_row(cbd_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, 32'h7fff_ffff,
            cbd_pkg::STATUS_OK);
    add_row(cbd_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, 32'd0,
            cbd_pkg::STATUS_UNDERFLOW);
    // fill to capacity from both ends, then push on full at each end
    for (int i = 0; i < Depth - 1; i++) begin
      add_row((i % 2) ? cbd_pkg::FUNC_PUSH_BACK : cbd_pkg::FUNC_PUSH_FRONT,
              (i % 3 == 0) ? 32'ha5a5_5a5a : ~(32'h0101_0101 * i), 1'b0, '0, '0);
    end
    add_row(cbd_pkg::FUNC_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'd0,
            cbd_pkg::STATUS_OVERFLOW);
    add_row(cbd_pkg::FUNC_PUSH_BACK,  32'h8765_4321, 1'b1, 32'd0,
            cbd_pkg::STATUS_OVERFLOW);
    add_row(cbd_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b0, '0, '0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 18));
      issue_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].fixed,
                    dir_rows[i].want_value, dir_rows[i].want_status);
    end

    // random part: bursts with their own push/pop mix and idling habit, so
    // the deque keeps running into both its full and empty corners
    sent       = 0;
    burst_left = 0;
    push_bias  = 50;
    idle_on    = 1'b0;
    while (sent < RandomReqs) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 60);
        push_bias  = $urandom_range(10, 90);
        idle_on    = $urandom_range(0, 2) != 0;
      end
      burst_left--;
      if ($urandom_range(1, 100) <= push_bias)
        op = $urandom_range(0, 1) ? cbd_pkg::FUNC_PUSH_BACK : cbd_pkg::FUNC_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? cbd_pkg::FUNC_POP_BACK : cbd_pkg::FUNC_POP_FRONT;
      if (idle_on && sent < RandomReqs - QuietTail && $urandom_range(0, 5) == 0)
        idle_gap($urandom_range(1, 18));
      // pops get junk on value_in as well, it must be ignored
      issue_request(op, pick_word());
      sent++;
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d pushes (%0d refused as full), %0d pops (%0d on empty)",
             req_cnt, push_cnt, overflow_cnt, pop_cnt, underflow_cnt);
    $display("deque reached %0d of %0d entries, %0d results checked, %0d mismatches",
             max_fill, Depth - 1, result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cbd_pkg.sv
sv/cbd_datapath.sv
sv/cbd_ctrl.sv
sv/circular_buffer_deque_unit.sv
bench/circular_buffer_deque_unit_tb.sv
